@@ sv/gradient_bitplane_window_words_defines.svh @@
// Assertion macros for the gradient bit-plane window block.
// Depends on a clock named clock and a reset named reset in the including scope.
`ifndef GRADIENT_BITPLANE_WINDOW_WORDS_DEFINES_SVH
`define GRADIENT_BITPLANE_WINDOW_WORDS_DEFINES_SVH

// check outside reset
`define GBW_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// check at every edge, reset included
`define GBW_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ sv/gbw_pkg.sv @@
// Shared types and constants for the gradient bit-plane window block.
// No dependencies.
package gbw_pkg;

   localparam int MAG_W     = 8;
   localparam int PLANES    = 4;
   localparam int FIRST_BIT = 4;
   localparam int WIN       = 8;
   localparam int BYTE_W    = 8;
   localparam int WORD_W    = WIN * BYTE_W;
   localparam int WIN_X_W   = 10;
   localparam int WIN_Y_W   = 12;
   localparam int CSR_W     = 11;
   localparam int RST_WIDTH = 640;
   localparam int RSP_DEPTH = 2;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   typedef logic [PLANES-1:0][WORD_W-1:0] plane_set_type;
   typedef logic [PLANES-1:0][BYTE_W-1:0] shift_set_type;

   typedef struct packed {
      plane_set_type        planes;
      logic [WIN_X_W-1:0]   win_x;
      logic [WIN_Y_W-1:0]   win_y;
   } rsp_word_type;

   typedef struct packed {
      logic                 valid;
      logic [RSP_CNT_W-1:0] count;
   } rsp_status_type;

endpackage

@@ sv/gradient_bitplane_window_words.sv @@
// Bit-plane window builder over a raster stream of 8-bit gradient magnitudes.
// Depends on gbw_pkg, gbw_line_store, gbw_rsp_fifo and the defines header.
//
// One pixel word is taken per clock cycle while the result queue has room, with no
// bubbles at row or frame boundaries; a result word goes from the stage 1 registers into
// the result queue, which offers it on rsp. The rate is set by the line store: each pixel
// does one read-modify-write of its column entry: the entry is read in the accept cycle
// into the store's output register and written back from stage 1 in the next,
// so two pixels are in flight at once. For magnitude bits 4 to 7 the block keeps a shift
// byte of the current row and, per column, the 8x8 window word of the row above; the new
// word is the stored word moved up one byte with the shift byte below it. A result word
// carries the four window words (top byte oldest row, bit 0 newest column) and the window's
// top-left corner, and is produced once column and row are both at least 7. The line
// store has no clearing pass: row 0 ignores what it reads. csr_image_width is clamped to
// [8, MAX_WIDTH] when written and must only be written while the block is idle. A two-word
// result queue lets pixels keep flowing while a result waits on rsp_ready.
module gradient_bitplane_window_words #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [gbw_pkg::MAG_W-1:0]     req_gradient_mag,
   input  logic                          req_frame_start,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [gbw_pkg::WORD_W-1:0]    rsp_plane_word_bit4,
   output logic [gbw_pkg::WORD_W-1:0]    rsp_plane_word_bit5,
   output logic [gbw_pkg::WORD_W-1:0]    rsp_plane_word_bit6,
   output logic [gbw_pkg::WORD_W-1:0]    rsp_plane_word_bit7,
   output logic [gbw_pkg::WIN_X_W-1:0]   rsp_window_x,
   output logic [gbw_pkg::WIN_Y_W-1:0]   rsp_window_y,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [gbw_pkg::CSR_W-1:0]     csr_image_width
);
   import gbw_pkg::*;

`include "gradient_bitplane_window_words_defines.svh"

   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int ROW_W   = $clog2(MAX_HEIGHT);
   localparam int FIT_W   = $clog2(MAX_WIDTH + 1);
   localparam int WID_W   = (FIT_W > CSR_W) ? FIT_W : CSR_W;
   localparam int RST_EFF = (RST_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RST_WIDTH;

   localparam logic [WID_W-1:0] WIDTH_MIN = WID_W'(WIN);
   localparam logic [WID_W-1:0] WIDTH_MAX = WID_W'(MAX_WIDTH);
   localparam logic [WID_W-1:0] WIDTH_RST = WID_W'(RST_EFF);
   localparam logic [ROW_W-1:0] ROW_LAST  = ROW_W'(MAX_HEIGHT - 1);
   localparam logic [COL_W-1:0] COL_EDGE  = COL_W'(WIN - 1);
   localparam logic [ROW_W-1:0] ROW_EDGE  = ROW_W'(WIN - 1);

   // ---------------------------------------------------------------- configuration
   logic [WID_W-1:0] width_ff, width_in;
   logic [WID_W-1:0] csr_ext;

   assign csr_ready = 1'b1;
   assign csr_ext   = WID_W'(csr_image_width);

   always_comb begin
      width_in = width_ff;
      if (csr_valid) begin
         // clamp once here, so the row-end compare sees a legal width
         if (csr_ext < WIDTH_MIN) begin
            width_in = WIDTH_MIN;
         end else if (csr_ext > WIDTH_MAX) begin
            width_in = WIDTH_MAX;
         end else begin
            width_in = csr_ext;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= WIDTH_RST;
      end else begin
         width_ff <= width_in;
      end
   end

   // ---------------------------------------------------------------- stage 0: accept
   logic                accept;
   logic                rsp_pop;
   logic [COL_W-1:0]    col_ff, col_in, col_cur;
   logic [ROW_W-1:0]    row_ff, row_in, row_cur;
   shift_set_type       bytes_ff, bytes_in;
   logic                row_start;
   logic                row_end;
   logic [WID_W-1:0]    col_plus;
   logic                emit_cur;
   logic [31:0]         win_x_full;
   logic [31:0]         win_y_full;
   rsp_status_type      fifo_status;
   logic [RSP_CNT_W:0]  occupancy;

   // stage 1 registers
   logic                s1_valid_ff;
   logic [COL_W-1:0]    s1_col_ff;
   logic                s1_row_zero_ff;
   logic                s1_emit_ff;
   shift_set_type       s1_bytes_ff;
   logic [WIN_X_W-1:0]  s1_win_x_ff;
   logic [WIN_Y_W-1:0]  s1_win_y_ff;

   // Hold a pixel back only when the queue could not absorb the word in flight plus
   // this one; a word leaving this cycle frees a slot.
   assign rsp_pop   = fifo_status.valid && rsp_ready;
   assign occupancy = (RSP_CNT_W + 1)'(fifo_status.count) + (RSP_CNT_W + 1)'(s1_valid_ff);
   assign req_ready = (occupancy < (RSP_CNT_W + 1)'(RSP_DEPTH)) || rsp_pop;
   assign accept    = req_valid && req_ready;

   // a frame start restarts position before the pixel is placed
   assign col_cur   = req_frame_start ? '0 : col_ff;
   assign row_cur   = req_frame_start ? '0 : row_ff;
   assign row_start = (col_cur == '0);

   always_comb begin
      for (int p = 0; p < PLANES; p++) begin
         // drop the previous row's bits at column 0, then shift in the new bit
         bytes_in[p] = {(row_start ? 7'b0 : bytes_ff[p][BYTE_W-2:0]),
                        req_gradient_mag[FIRST_BIT + p]};
      end
   end

   assign col_plus = WID_W'(col_cur) + WID_W'(1);
   // a width cut below the current column still ends the row here
   assign row_end  = (col_plus >= width_ff);
   assign col_in   = row_end ? '0 : COL_W'(col_plus);
   assign row_in   = (row_end && (row_cur != ROW_LAST)) ? row_cur + 1'b1 : row_cur;

   assign emit_cur   = (col_cur >= COL_EDGE) && (row_cur >= ROW_EDGE);
   assign win_x_full = 32'(col_cur) - 32'(WIN - 1);
   assign win_y_full = 32'(row_cur) - 32'(WIN - 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         bytes_ff    <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         if (accept) begin
            col_ff   <= col_in;
            row_ff   <= row_in;
            bytes_ff <= bytes_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_col_ff      <= col_cur;
         s1_row_zero_ff <= (row_cur == '0);
         s1_emit_ff     <= emit_cur;
         s1_bytes_ff    <= bytes_in;
         s1_win_x_ff    <= win_x_full[WIN_X_W-1:0];
         s1_win_y_ff    <= win_y_full[WIN_Y_W-1:0];
      end
   end

   // ---------------------------------------------------------------- line store
   plane_set_type above_raw;
   plane_set_type above;
   plane_set_type words;

   gbw_line_store #(
      .DEPTH  (MAX_WIDTH),
      .ADDR_W (COL_W)
   ) u_line_store (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (col_cur),
      .rd_data (above_raw),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_col_ff),
      .wr_data (words)
   );

   // ---------------------------------------------------------------- stage 1: build and write back
   // row 0 has nothing above it, whatever the store holds
   assign above = s1_row_zero_ff ? '0 : above_raw;

   always_comb begin
      for (int p = 0; p < PLANES; p++) begin
         words[p] = {above[p][WORD_W-BYTE_W-1:0], s1_bytes_ff[p]};
      end
   end

   // ---------------------------------------------------------------- result queue
   rsp_word_type push_word;
   rsp_word_type head_word;
   logic         push;

   assign push             = s1_valid_ff && s1_emit_ff;
   assign push_word.planes = words;
   assign push_word.win_x  = s1_win_x_ff;
   assign push_word.win_y  = s1_win_y_ff;

   gbw_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_word),
      .pop       (rsp_pop),
      .head_data (head_word),
      .status    (fifo_status)
   );

   assign rsp_valid           = fifo_status.valid;
   assign rsp_plane_word_bit4 = head_word.planes[0];
   assign rsp_plane_word_bit5 = head_word.planes[1];
   assign rsp_plane_word_bit6 = head_word.planes[2];
   assign rsp_plane_word_bit7 = head_word.planes[3];
   assign rsp_window_x        = head_word.win_x;
   assign rsp_window_y        = head_word.win_y;

   // ---------------------------------------------------------------- checks
   logic rmw_hazard;
   logic in_flight;

   // a pixel reading the entry still being written back would see stale data
   assign rmw_hazard = accept && s1_valid_ff && (row_cur != '0) && (col_cur == s1_col_ff);
   assign in_flight  = rsp_valid || s1_valid_ff;

   // the queue never has to take a word it has no room for
   `GBW_ASSERT(a_queue_room, occupancy <= (RSP_CNT_W + 1)'(RSP_DEPTH), "result queue overrun")
   `GBW_ASSERT(a_no_rmw_overlap, !rmw_hazard, "line store read overlaps pending write")
   // a result only appears after a windowed pixel left stage 1
   `GBW_ASSERT(a_rsp_from_window, $rose(rsp_valid) |-> $past(push), "result without a window")
   // nothing is in flight on the first edge out of reset
   `GBW_ASSERT_ALWAYS(a_reset_quiet, (!reset && $past(reset)) |-> !in_flight, "busy after reset")

endmodule

@@ sv/gbw_line_store.sv @@
// Line store: one window word per plane and column, one read and one write port.
// Depends on gbw_pkg for the plane word type.
module gbw_line_store #(
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = 10
) (
   input  logic                   clock,
   input  logic                   rd_en,
   input  logic [ADDR_W-1:0]      rd_addr,
   output gbw_pkg::plane_set_type rd_data,
   input  logic                   wr_en,
   input  logic [ADDR_W-1:0]      wr_addr,
   input  gbw_pkg::plane_set_type wr_data
);
   import gbw_pkg::*;

   plane_set_type mem [DEPTH];
   plane_set_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/gbw_rsp_fifo.sv @@
// Two-entry result queue between the window pipeline and the rsp channel.
// Depends on gbw_pkg for the result word and status types.
module gbw_rsp_fifo (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  gbw_pkg::rsp_word_type   push_data,
   input  logic                    pop,
   output gbw_pkg::rsp_word_type   head_data,
   output gbw_pkg::rsp_status_type status
);
   import gbw_pkg::*;

   rsp_word_type           entry_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0]   head_ff, head_in;
   logic [RSP_PTR_W-1:0]   tail_ff, tail_in;
   logic [RSP_CNT_W-1:0]   count_ff, count_in;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (pop) begin
         head_in = (head_ff == RSP_PTR_W'(RSP_DEPTH - 1)) ? '0 : head_ff + 1'b1;
      end
      if (push) begin
         tail_in = (tail_ff == RSP_PTR_W'(RSP_DEPTH - 1)) ? '0 : tail_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[tail_ff] <= push_data;
      end
   end

   assign head_data    = entry_ff[head_ff];
   assign status.valid = (count_ff != '0);
   assign status.count = count_ff;

endmodule
